>>> sv/ppm_pkg.sv
`default_nettype none

package ppm_pkg;

    localparam int ANG_FRAC     = 24;
    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 32;
    localparam int UNIT_FRAC    = 30;

    // configuration register indexes
    localparam logic [0:0] REG_MAX_ANGLE  = 1'b0;
    localparam logic [0:0] REG_MAX_OFFSET = 1'b1;

    localparam logic [23:0] ANGLE_RESET  = 24'd655360;
    localparam logic [30:0] OFFSET_RESET = 31'd13107;
    localparam logic [30:0] OFFSET_MAX   = 31'h7FFF_FFFF;
    localparam logic [23:0] ANGLE_MAX    = 24'hFF_FFFF;

    // arctangent of 2^-i in degrees, 24 fraction bits
    localparam logic [31:0] ATAN_DEG [CORDIC_STEPS] = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
        32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
        32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671,
        32'd29335, 32'd14668, 32'd7334, 32'd3667, 32'd1833,
        32'd917, 32'd458, 32'd229, 32'd115, 32'd57,
        32'd29, 32'd14, 32'd7, 32'd4, 32'd2
    };

    typedef struct packed {
        logic [63:0] rad;
        logic [34:0] rem;
        logic [31:0] root;
    } sqrt_t;

    typedef struct packed {
        logic       vld;
        logic [1:0] ok;
    } norm_ctl_t;

    // one result bit of a digit-by-digit square root
    function automatic sqrt_t sqrt_step(input sqrt_t a);
        sqrt_t       o;
        logic [34:0] r;
        logic [34:0] trial;
        r     = {a.rem[32:0], a.rad[63:62]};
        trial = {1'b0, a.root, 2'b01};
        o.rad = {a.rad[61:0], 2'b00};
        if (r >= trial)
        begin
            o.rem  = r - trial;
            o.root = {a.root[30:0], 1'b1};
        end
        else
        begin
            o.rem  = r;
            o.root = {a.root[30:0], 1'b0};
        end
        return o;
    endfunction

    // one restoring division step, returns {quotient bit, remainder}
    function automatic logic [32:0] div_step(input logic [31:0] rem, input logic [31:0] den);
        logic [32:0] t;
        logic [32:0] d;
        t = {rem, 1'b0};
        d = {1'b0, den};
        if (t >= d)
        begin
            t = t - d;
            return {1'b1, t[31:0]};
        end
        return {1'b0, t[31:0]};
    endfunction

endpackage

`default_nettype wire

>>> sv/ppm_norm.sv
`default_nettype none

module ppm_norm
    import ppm_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 en,
    input  wire logic                                 vld_in,
    input  wire logic [1:0][3:0][31:0]                coef,
    output norm_ctl_t                                 ctl,
    output logic      [1:0][2:0][31:0]                unit,
    output logic      [1:0][FRAC_BITS+UNIT_FRAC+2:0]  off
);

    localparam int K   = FRAC_BITS + UNIT_FRAC;
    localparam int QW  = K + 2;
    localparam int OW  = QW + 1;
    localparam int LAT = 5 + SQRT_STEPS + K + 2;

    typedef struct packed {
        logic             ok;
        logic [3:0]       ng;
        logic [4:0]       sh;
        logic [3:0][31:0] num;
    } pcar_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] ng;
        logic [4:0] sh;
    } dcar_t;

    logic [LAT-1:0] vld_reg;

    logic [31:0] m1_reg  [2][4];
    logic [3:0]  ng1_reg [2];
    logic [31:0] m2_reg  [2][4];
    logic [3:0]  ng2_reg [2];
    logic [4:0]  sh2_reg [2];
    logic        ok2_reg [2];
    pcar_t       car3_reg [2];
    pcar_t       car4_reg [2];
    pcar_t       car5_reg [2];
    logic [63:0] sq4_reg  [2][3];
    logic [63:0] sum5_reg [2];
    sqrt_t       sqs_reg  [2][SQRT_STEPS];
    pcar_t       sqc_reg  [2][SQRT_STEPS];
    logic [31:0] dr_reg   [2][K+1][4];
    logic [QW-1:0] dq_reg [2][K+1][4];
    logic [31:0] dn_reg   [2][K+1];
    dcar_t       dc_reg   [2][K+1];
    logic [1:0]  ok_reg;
    logic [1:0][2:0][31:0] unit_reg;
    logic [1:0][OW-1:0]    off_reg;

    logic [4:0]  sh_w  [2];
    logic        nz_w  [2];
    logic [1:0]  iq_w  [2][4];
    logic [31:0] ir_w  [2][4];
    logic [32:0] ds_w  [2][K][4];
    logic [31:0] fu_w  [2][3];
    logic [OW-1:0] fo_w [2];

    // leading-one search on the largest normal component
    always_comb
    begin
        logic [31:0] mx;
        for (int l = 0; l < 2; l++)
        begin
            mx = m1_reg[l][0];
            if (m1_reg[l][1] > mx)
                mx = m1_reg[l][1];
            if (m1_reg[l][2] > mx)
                mx = m1_reg[l][2];
            sh_w[l] = '0;
            for (int i = 0; i < 31; i++)
                if (mx[i])
                    sh_w[l] = 5'(30 - i);
            nz_w[l] = (mx != '0);
        end
    end

    // integer part of the quotients: numerator is at most twice the length
    always_comb
    begin
        logic [31:0] n;
        logic [32:0] two;
        logic [32:0] num;
        for (int l = 0; l < 2; l++)
        begin
            n   = sqs_reg[l][SQRT_STEPS-1].root;
            two = {n, 1'b0};
            for (int j = 0; j < 4; j++)
            begin
                num = {1'b0, sqc_reg[l][SQRT_STEPS-1].num[j]};
                if (num >= two)
                begin
                    iq_w[l][j] = 2'd2;
                    ir_w[l][j] = 32'(num - two);
                end
                else if (num[31:0] >= n)
                begin
                    iq_w[l][j] = 2'd1;
                    ir_w[l][j] = num[31:0] - n;
                end
                else
                begin
                    iq_w[l][j] = 2'd0;
                    ir_w[l][j] = num[31:0];
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 2; l++)
            for (int t = 0; t < K; t++)
                for (int j = 0; j < 4; j++)
                    ds_w[l][t][j] = div_step(dr_reg[l][t][j], dn_reg[l][t]);
    end

    // unit components drop the extra fraction bits, offset undoes the normal shift
    always_comb
    begin
        logic [30:0]   uq;
        logic [QW-1:0] oq;
        for (int l = 0; l < 2; l++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                uq = 31'(dq_reg[l][K][j] >> FRAC_BITS);
                fu_w[l][j] = dc_reg[l][K].ng[j] ? (32'd0 - {1'b0, uq}) : {1'b0, uq};
            end
            oq = dq_reg[l][K][3] >> (5'd30 - dc_reg[l][K].sh);
            fo_w[l] = dc_reg[l][K].ng[3] ? (OW'(0) - {1'b0, oq}) : {1'b0, oq};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], vld_in};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 2; l++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    ng1_reg[l][j] <= coef[l][j][31];
                    m1_reg[l][j]  <= coef[l][j][31] ? (32'd0 - coef[l][j]) : coef[l][j];
                    m2_reg[l][j]  <= m1_reg[l][j];
                end
                ng2_reg[l] <= ng1_reg[l];
                sh2_reg[l] <= sh_w[l];
                ok2_reg[l] <= nz_w[l];

                car3_reg[l].ok <= ok2_reg[l];
                car3_reg[l].ng <= ng2_reg[l];
                car3_reg[l].sh <= sh2_reg[l];
                for (int j = 0; j < 3; j++)
                    car3_reg[l].num[j] <= m2_reg[l][j] << sh2_reg[l];
                car3_reg[l].num[3] <= m2_reg[l][3];

                for (int j = 0; j < 3; j++)
                    sq4_reg[l][j] <= car3_reg[l].num[j] * car3_reg[l].num[j];
                car4_reg[l] <= car3_reg[l];

                sum5_reg[l] <= sq4_reg[l][0] + sq4_reg[l][1] + sq4_reg[l][2];
                car5_reg[l] <= car4_reg[l];

                sqs_reg[l][0] <= sqrt_step(sqrt_t'{rad: sum5_reg[l], rem: '0, root: '0});
                sqc_reg[l][0] <= car5_reg[l];
                for (int k = 1; k < SQRT_STEPS; k++)
                begin
                    sqs_reg[l][k] <= sqrt_step(sqs_reg[l][k-1]);
                    sqc_reg[l][k] <= sqc_reg[l][k-1];
                end

                for (int j = 0; j < 4; j++)
                begin
                    dq_reg[l][0][j] <= QW'(iq_w[l][j]);
                    dr_reg[l][0][j] <= ir_w[l][j];
                end
                dn_reg[l][0]    <= sqs_reg[l][SQRT_STEPS-1].root;
                dc_reg[l][0].ok <= sqc_reg[l][SQRT_STEPS-1].ok;
                dc_reg[l][0].ng <= sqc_reg[l][SQRT_STEPS-1].ng;
                dc_reg[l][0].sh <= sqc_reg[l][SQRT_STEPS-1].sh;
                for (int t = 1; t <= K; t++)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        dq_reg[l][t][j] <= {dq_reg[l][t-1][j][QW-2:0], ds_w[l][t-1][j][32]};
                        dr_reg[l][t][j] <= ds_w[l][t-1][j][31:0];
                    end
                    dn_reg[l][t] <= dn_reg[l][t-1];
                    dc_reg[l][t] <= dc_reg[l][t-1];
                end

                ok_reg[l] <= dc_reg[l][K].ok;
                for (int j = 0; j < 3; j++)
                    unit_reg[l][j] <= fu_w[l][j];
                off_reg[l] <= fo_w[l];
            end
        end
    end

    assign ctl.vld = vld_reg[LAT-1];
    assign ctl.ok  = ok_reg;
    assign unit    = unit_reg;
    assign off     = off_reg;

endmodule

`default_nettype wire

>>> sv/plane_pair_match_top.sv
// channel   | direction | handshake              | payload
// pair      | in        | pair_valid / pair_stall | first_a..first_d, second_a..second_d
// res       | out       | res_valid / res_stall   | valid_res, matched, angle_deg, offset_diff
// cfg       | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one plane pair enters per clock while pair_stall is low; the pipeline depth is set
// by the bit-per-stage square roots, the restoring dividers (FRAC_BITS + 31 stages)
// and the 30 arctangent stages.
// rst_n clears every valid bit and loads the limit registers; data is not reset.
// a stalled result freezes the whole pipeline, pair_stall follows it directly.
// cfg_ready is always high.
`default_nettype none

module plane_pair_match_top
    import ppm_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pair_valid,
    output logic             pair_stall,
    input  wire logic [31:0] first_a,
    input  wire logic [31:0] first_b,
    input  wire logic [31:0] first_c,
    input  wire logic [31:0] first_d,
    input  wire logic [31:0] second_a,
    input  wire logic [31:0] second_b,
    input  wire logic [31:0] second_c,
    input  wire logic [31:0] second_d,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic             valid_res,
    output logic             matched,
    output logic [23:0]      angle_deg,
    output logic [30:0]      offset_diff,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int OW  = FRAC_BITS + UNIT_FRAC + 3;
    localparam int ASH = ANG_FRAC - FRAC_BITS;
    localparam logic [63:0] BAD_ANG_W = 64'd180 << FRAC_BITS;
    localparam logic [23:0] BAD_ANG   = (BAD_ANG_W > 64'hFF_FFFF) ? ANGLE_MAX : BAD_ANG_W[23:0];
    localparam logic [31:0] MAX_Z     = 32'd90 << ANG_FRAC;
    localparam logic [OW:0] OFF_SAT   = {{(OW-30){1'b0}}, OFFSET_MAX};
    localparam logic [63:0] ONE_W     = 64'd1 << UNIT_FRAC;

    typedef struct packed {
        logic        ok;
        logic [30:0] cs;
        logic [30:0] offd;
    } tcar_t;

    logic en;
    logic [23:0] max_angle_reg;
    logic [30:0] max_offset_reg;

    norm_ctl_t             nctl;
    logic [1:0][3:0][31:0] coef;
    logic [1:0][2:0][31:0] unit;
    logic [1:0][OW-1:0]    off;

    logic [4:0]                tv_reg;
    logic [SQRT_STEPS-1:0]     sv_reg;
    logic [CORDIC_STEPS-1:0]   cv_reg;
    logic                      res_valid_reg;

    logic signed [31:0] u1_w [3];
    logic signed [31:0] u2_w [3];
    logic signed [63:0] dp_reg [3];
    logic signed [63:0] cp_reg [6];
    logic [OW-1:0] of1_reg, of2_reg, of1b_reg, of2b_reg;
    logic          ok1_reg, ok2_reg, ok3_reg, ok4_reg;
    logic [63:0]   dot_reg;
    logic [63:0]   cr_reg [3];
    logic [30:0]   cs3_reg, cs4_reg;
    logic [31:0]   t3_reg [3];
    logic [OW:0]   diff3_reg;
    logic [63:0]   ts4_reg [3];
    logic [30:0]   offd4_reg;
    logic [63:0]   ssum5_reg;
    tcar_t         car5_reg;
    sqrt_t         ss_reg [SQRT_STEPS];
    tcar_t         sc_reg [SQRT_STEPS];
    logic signed [35:0] cx_reg [CORDIC_STEPS];
    logic signed [35:0] cy_reg [CORDIC_STEPS];
    logic signed [31:0] cz_reg [CORDIC_STEPS];
    tcar_t              cc_reg [CORDIC_STEPS];
    logic signed [35:0] cx_next [CORDIC_STEPS];
    logic signed [35:0] cy_next [CORDIC_STEPS];
    logic signed [31:0] cz_next [CORDIC_STEPS];

    logic        valid_res_reg, matched_reg;
    logic [23:0] angle_reg;
    logic [30:0] offd_reg;

    logic [30:0] cs_w;
    logic [31:0] t_w [3];
    logic [OW:0] diff_w;
    logic [30:0] offd_w;
    logic [31:0] zc_w, zr_w;
    logic [23:0] ang_w;

    assign en         = !(res_valid_reg && res_stall);
    assign pair_stall = !en;
    assign cfg_ready  = 1'b1;

    assign coef[0] = {first_d, first_c, first_b, first_a};
    assign coef[1] = {second_d, second_c, second_b, second_a};

    ppm_norm #(
        .FRAC_BITS (FRAC_BITS)
    ) u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .vld_in (pair_valid),
        .coef   (coef),
        .ctl    (nctl),
        .unit   (unit),
        .off    (off)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_angle_reg  <= ANGLE_RESET;
            max_offset_reg <= OFFSET_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MAX_ANGLE:  max_angle_reg  <= cfg_data[23:0];
                REG_MAX_OFFSET: max_offset_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u1_w[i] = $signed(unit[0][i]);
            u2_w[i] = $signed(unit[1][i]);
        end
    end

    // cosine clamp, cross magnitudes, offset difference with the flip applied
    always_comb
    begin
        logic [63:0] mag;
        logic [63:0] cq;
        logic [OW:0] e1, e2, dm;
        mag  = dot_reg[63] ? (64'd0 - dot_reg) : dot_reg;
        cq   = mag >> UNIT_FRAC;
        cs_w = (cq > ONE_W) ? 31'(ONE_W) : cq[30:0];
        for (int i = 0; i < 3; i++)
        begin
            mag    = cr_reg[i][63] ? (64'd0 - cr_reg[i]) : cr_reg[i];
            t_w[i] = 32'(mag >> UNIT_FRAC);
        end
        e1     = {of1b_reg[OW-1], of1b_reg};
        e2     = {of2b_reg[OW-1], of2b_reg};
        if (dot_reg[63])
            e2 = (OW+1)'(0) - e2;
        diff_w = e1 - e2;
        dm     = diff3_reg[OW] ? ((OW+1)'(0) - diff3_reg) : diff3_reg;
        offd_w = (dm > OFF_SAT) ? OFFSET_MAX : dm[30:0];
    end

    // vectoring rotation toward the x axis, angle gathered in z
    always_comb
    begin
        logic signed [35:0] px, py;
        logic signed [31:0] pz;
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            if (k == 0)
            begin
                px = $signed({5'd0, sc_reg[SQRT_STEPS-1].cs});
                py = $signed({4'd0, ss_reg[SQRT_STEPS-1].root});
                pz = '0;
            end
            else
            begin
                px = cx_reg[k-1];
                py = cy_reg[k-1];
                pz = cz_reg[k-1];
            end
            if (!py[35])
            begin
                cx_next[k] = px + (py >>> k);
                cy_next[k] = py - (px >>> k);
                cz_next[k] = pz + $signed(ATAN_DEG[k]);
            end
            else
            begin
                cx_next[k] = px - (py >>> k);
                cy_next[k] = py + (px >>> k);
                cz_next[k] = pz - $signed(ATAN_DEG[k]);
            end
        end
    end

    always_comb
    begin
        if (cz_reg[CORDIC_STEPS-1][31])
            zc_w = '0;
        else if ($unsigned(cz_reg[CORDIC_STEPS-1]) > MAX_Z)
            zc_w = MAX_Z;
        else
            zc_w = $unsigned(cz_reg[CORDIC_STEPS-1]);
    end

    if (ASH > 0)
    begin : g_round
        assign zr_w = (zc_w + (32'd1 << (ASH - 1))) >> ASH;
    end
    else
    begin : g_noround
        assign zr_w = zc_w;
    end

    assign ang_w = (zr_w > 32'(ANGLE_MAX)) ? ANGLE_MAX : zr_w[23:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg        <= '0;
            sv_reg        <= '0;
            cv_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            tv_reg        <= {tv_reg[3:0], nctl.vld};
            sv_reg        <= {sv_reg[SQRT_STEPS-2:0], tv_reg[4]};
            cv_reg        <= {cv_reg[CORDIC_STEPS-2:0], sv_reg[SQRT_STEPS-1]};
            res_valid_reg <= cv_reg[CORDIC_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                dp_reg[i] <= u1_w[i] * u2_w[i];
            cp_reg[0] <= u1_w[1] * u2_w[2];
            cp_reg[1] <= u1_w[2] * u2_w[1];
            cp_reg[2] <= u1_w[2] * u2_w[0];
            cp_reg[3] <= u1_w[0] * u2_w[2];
            cp_reg[4] <= u1_w[0] * u2_w[1];
            cp_reg[5] <= u1_w[1] * u2_w[0];
            of1_reg   <= off[0];
            of2_reg   <= off[1];
            ok1_reg   <= nctl.ok[0] && nctl.ok[1];

            dot_reg   <= $unsigned(dp_reg[0] + dp_reg[1] + dp_reg[2]);
            cr_reg[0] <= $unsigned(cp_reg[0] - cp_reg[1]);
            cr_reg[1] <= $unsigned(cp_reg[2] - cp_reg[3]);
            cr_reg[2] <= $unsigned(cp_reg[4] - cp_reg[5]);
            of1b_reg  <= of1_reg;
            of2b_reg  <= of2_reg;
            ok2_reg   <= ok1_reg;

            cs3_reg   <= cs_w;
            for (int i = 0; i < 3; i++)
                t3_reg[i] <= t_w[i];
            diff3_reg <= diff_w;
            ok3_reg   <= ok2_reg;

            for (int i = 0; i < 3; i++)
                ts4_reg[i] <= t3_reg[i] * t3_reg[i];
            offd4_reg <= offd_w;
            cs4_reg   <= cs3_reg;
            ok4_reg   <= ok3_reg;

            ssum5_reg     <= ts4_reg[0] + ts4_reg[1] + ts4_reg[2];
            car5_reg.ok   <= ok4_reg;
            car5_reg.cs   <= cs4_reg;
            car5_reg.offd <= offd4_reg;

            ss_reg[0] <= sqrt_step(sqrt_t'{rad: ssum5_reg, rem: '0, root: '0});
            sc_reg[0] <= car5_reg;
            for (int k = 1; k < SQRT_STEPS; k++)
            begin
                ss_reg[k] <= sqrt_step(ss_reg[k-1]);
                sc_reg[k] <= sc_reg[k-1];
            end

            for (int k = 0; k < CORDIC_STEPS; k++)
            begin
                cx_reg[k] <= cx_next[k];
                cy_reg[k] <= cy_next[k];
                cz_reg[k] <= cz_next[k];
                cc_reg[k] <= (k == 0) ? sc_reg[SQRT_STEPS-1] : cc_reg[k-1];
            end

            if (cc_reg[CORDIC_STEPS-1].ok)
            begin
                valid_res_reg <= 1'b1;
                matched_reg   <= (ang_w <= max_angle_reg) &&
                                 (cc_reg[CORDIC_STEPS-1].offd <= max_offset_reg);
                angle_reg     <= ang_w;
                offd_reg      <= cc_reg[CORDIC_STEPS-1].offd;
            end
            else
            begin
                valid_res_reg <= 1'b0;
                matched_reg   <= 1'b0;
                angle_reg     <= BAD_ANG;
                offd_reg      <= OFFSET_MAX;
            end
        end
    end

    assign res_valid   = res_valid_reg;
    assign valid_res   = valid_res_reg;
    assign matched     = matched_reg;
    assign angle_deg   = angle_reg;
    assign offset_diff = offd_reg;

endmodule

`default_nettype wire

>>> sv/ppm_check.sv
`default_nettype none

module ppm_check #(
    parameter int FRAC_BITS = 16
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        pair_valid,
    input wire logic        pair_stall,
    input wire logic [31:0] first_a,
    input wire logic [31:0] first_b,
    input wire logic [31:0] first_c,
    input wire logic [31:0] first_d,
    input wire logic [31:0] second_a,
    input wire logic [31:0] second_b,
    input wire logic [31:0] second_c,
    input wire logic [31:0] second_d,
    input wire logic        res_valid,
    input wire logic        res_stall,
    input wire logic        valid_res,
    input wire logic        matched,
    input wire logic [23:0] angle_deg,
    input wire logic [30:0] offset_diff,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [0:0]  cfg_index,
    input wire logic [31:0] cfg_data
);

    localparam logic [63:0] BAD_W  = 64'd180 << FRAC_BITS;
    localparam logic [23:0] BAD    = (BAD_W > 64'hFF_FFFF) ? 24'hFF_FFFF : BAD_W[23:0];
    localparam logic [63:0] RIGHT_W = 64'd90 << FRAC_BITS;
    localparam logic [23:0] RIGHT  = (RIGHT_W > 64'hFF_FFFF) ? 24'hFF_FFFF : RIGHT_W[23:0];

    // a degenerate plane reports saturated values and never matches
    a_bad_plane: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !valid_res |->
            !matched && offset_diff == 31'h7FFF_FFFF && angle_deg == BAD)
        else $error("degenerate plane result not saturated");

    // a valid angle is folded into the first quadrant
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && valid_res |-> angle_deg <= RIGHT)
        else $error("angle beyond a right angle");

    // input only backs up while a result sits stalled at the output
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        pair_stall |-> res_valid && res_stall)
        else $error("input stalled without output back-pressure");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=>
            res_valid && $stable(angle_deg) && $stable(offset_diff) && $stable(matched))
        else $error("stalled result changed");

endmodule

bind plane_pair_match_top ppm_check #(.FRAC_BITS(FRAC_BITS)) u_ppm_check (.*);

`default_nettype wire
